FILE: hdl/dertlh_pkg.sv
// shared types and constants for the der tag-length header parser
package dertlh_pkg;

  // parse phase of the current header
  typedef enum logic [1:0] {
    PH_IDENT    = 2'd0,
    PH_TAGCONT  = 2'd1,
    PH_LEN      = 2'd2,
    PH_LENBYTES = 2'd3
  } phase_t;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EOC   = 2'd1;
  localparam logic [1:0] STAT_INDEF = 2'd2;
  localparam logic [1:0] STAT_TRUNC = 2'd3;

  // byte field constants
  localparam logic [4:0] TAG_LONG_FORM  = 5'h1f;
  localparam logic [7:0] LEN_INDEF_BYTE = 8'h80;
  localparam logic [7:0] COUNT_MAX      = 8'hff;

  // one decoded header
  typedef struct packed {
    logic [7:0]  header_bytes;
    logic [31:0] content_length;
    logic [31:0] tag_number;
    logic [1:0]  tag_class;
    logic [1:0]  status;
  } result_t;

endpackage

FILE: hdl/dertlh_step.sv
// per-byte header parse logic: next state and result from the current state
module dertlh_step
  import dertlh_pkg::*;
#(
  parameter int TAG_WIDTH    = 32,
  parameter int LENGTH_WIDTH = 32
) (
  input  phase_t                  phase_i,
  input  logic [7:0]              ident_i,
  input  logic [TAG_WIDTH-1:0]    tag_acc_i,
  input  logic [LENGTH_WIDTH-1:0] len_acc_i,
  input  logic [6:0]              left_i,
  input  logic [7:0]              count_i,
  input  logic [7:0]              byte_i,
  input  logic                    eos_i,
  output phase_t                  phase_o,
  output logic [7:0]              ident_o,
  output logic [TAG_WIDTH-1:0]    tag_acc_o,
  output logic [LENGTH_WIDTH-1:0] len_acc_o,
  output logic [6:0]              left_o,
  output logic [7:0]              count_o,
  output logic                    res_valid_o,
  output result_t                 res_o
);

  localparam int TagExtW = (TAG_WIDTH > 32) ? TAG_WIDTH : 32;
  localparam int LenExtW = (LENGTH_WIDTH > 32) ? LENGTH_WIDTH : 32;

  logic [7:0]              count_inc;
  logic [LENGTH_WIDTH-1:0] len_shift;
  logic [6:0]              left_dec;
  logic [TagExtW-1:0]      tag_ext;
  logic [LenExtW-1:0]      len_ext;
  logic [31:0]             tag_num;
  logic                    long_tag;

  // shared arithmetic
  assign count_inc = (count_i == COUNT_MAX) ? count_i : count_i + 8'd1;
  assign len_shift = LENGTH_WIDTH'({len_acc_i, byte_i});
  assign left_dec  = (left_i != 7'd0) ? left_i - 7'd1 : left_i;
  assign tag_ext   = TagExtW'(tag_acc_i);
  assign len_ext   = LenExtW'(len_shift);
  assign long_tag  = (ident_i[4:0] == TAG_LONG_FORM);
  assign tag_num   = long_tag ? tag_ext[31:0] : {27'd0, ident_i[4:0]};

  // next state
  always_comb begin
    phase_o   = phase_i;
    ident_o   = ident_i;
    tag_acc_o = tag_acc_i;
    len_acc_o = len_acc_i;
    left_o    = left_i;
    count_o   = count_i;
    if (eos_i) begin
      phase_o = PH_IDENT;
    end else begin
      count_o = count_inc;
      case (phase_i)
        PH_IDENT: begin
          ident_o   = byte_i;
          tag_acc_o = '0;
          len_acc_o = '0;
          left_o    = 7'd0;
          count_o   = 8'd1;
          phase_o   = (byte_i[4:0] == TAG_LONG_FORM) ? PH_TAGCONT : PH_LEN;
        end
        PH_TAGCONT: begin
          tag_acc_o = TAG_WIDTH'({tag_acc_i, byte_i[6:0]});
          if (!byte_i[7]) phase_o = PH_LEN;
        end
        PH_LEN: begin
          if (byte_i[7] && byte_i != LEN_INDEF_BYTE) begin
            left_o    = byte_i[6:0];
            len_acc_o = '0;
            phase_o   = PH_LENBYTES;
          end else if (byte_i[7] || (byte_i == 8'd0 && ident_i == 8'd0) || !byte_i[7]) begin
            phase_o = PH_IDENT;
          end
        end
        PH_LENBYTES: begin
          len_acc_o = len_shift;
          left_o    = left_dec;
          if (left_dec == 7'd0) phase_o = PH_IDENT;
        end
        default: phase_o = PH_IDENT;
      endcase
    end
  end

  // result
  always_comb begin
    res_valid_o        = 1'b0;
    res_o.status       = STAT_OK;
    res_o.tag_class    = ident_i[7:6];
    res_o.tag_number   = tag_num;
    res_o.content_length = 32'd0;
    res_o.header_bytes = count_inc;
    if (eos_i) begin
      // truncated header carries only the byte count
      res_valid_o        = (phase_i != PH_IDENT);
      res_o.status       = STAT_TRUNC;
      res_o.tag_class    = 2'd0;
      res_o.tag_number   = 32'd0;
      res_o.header_bytes = count_i;
    end else begin
      case (phase_i)
        PH_LEN: begin
          if (byte_i == 8'd0 && ident_i == 8'd0) begin
            res_valid_o  = 1'b1;
            res_o.status = STAT_EOC;
          end else if (byte_i == LEN_INDEF_BYTE) begin
            res_valid_o  = 1'b1;
            res_o.status = STAT_INDEF;
          end else if (!byte_i[7]) begin
            res_valid_o          = 1'b1;
            res_o.content_length = {24'd0, byte_i};
          end
        end
        PH_LENBYTES: begin
          if (left_dec == 7'd0) begin
            res_valid_o          = 1'b1;
            res_o.content_length = len_ext[31:0];
          end
        end
        default: res_valid_o = 1'b0;
      endcase
    end
  end

endmodule

FILE: hdl/dertlh_out_reg.sv
// result register holding one decoded header until the receiver takes it
module dertlh_out_reg
  import dertlh_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load_i,
  input  result_t res_i,
  input  logic    out_tready,
  output logic    out_valid_o,
  output logic    free_o,
  output result_t res_o
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  // the slot can take a new result when empty or being drained
  assign free_o = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) valid_nxt = 1'b1;
    else if (out_tready) valid_nxt = 1'b0;
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load_i) res_r <= res_i;
  end

  assign out_valid_o = valid_r;
  assign res_o       = res_r;

endmodule

FILE: hdl/der_tag_length_header_parser_core.sv
// top level of the der tag-length header parser
//
// Byte stream in on the in_ channel: in_tdata[7:0] is the next encoded byte,
// in_tuser marks end of stream (no byte). Every accepted byte advances the
// header state held in this module; when a header completes, or ends in an
// error, one decoded item goes to the out_ channel: out_tuser is the status
// (ok, end-of-contents, indefinite length, truncated header) and out_tdata
// carries class, tag number, content length and header byte count.
// Throughput is one byte per cycle while in_tready is high: the only loop is
// the update of the header state registers. out_tvalid rises in the cycle
// after the accepted byte that finishes a header, as the result register loads.
// When the receiver stalls, the result register holds its item and
// in_tready drops only while a result waits and out_tready is low; a byte
// that produces no result is still needed to wait then, since the next
// result could land at any byte.
// Synchronous reset puts the parser back at the start of a header and
// empties the result register.
module der_tag_length_header_parser_core
  import dertlh_pkg::*;
#(
  parameter int TAG_WIDTH    = 32,
  parameter int LENGTH_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte[7:0]
  input  logic        in_tuser,   // end_of_stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // tag_class[1:0], tag_number[33:2], content_length[65:34],
  // header_bytes[73:66], zero fill [79:74]
  output logic [79:0] out_tdata,
  output logic [1:0]  out_tuser   // status
);

  phase_t                  phase_r, phase_nxt;
  logic [7:0]              ident_r, ident_nxt;
  logic [TAG_WIDTH-1:0]    tag_acc_r, tag_acc_nxt;
  logic [LENGTH_WIDTH-1:0] len_acc_r, len_acc_nxt;
  logic [6:0]              left_r, left_nxt;
  logic [7:0]              count_r, count_nxt;
  logic                    res_valid;
  result_t                 res, res_q;
  logic                    slot_free;
  logic                    in_acc;

  assign in_tready = slot_free;
  assign in_acc    = in_tvalid && in_tready;

  // parse logic for one byte
  dertlh_step #(
    .TAG_WIDTH   (TAG_WIDTH),
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_step (
    .phase_i    (phase_r),
    .ident_i    (ident_r),
    .tag_acc_i  (tag_acc_r),
    .len_acc_i  (len_acc_r),
    .left_i     (left_r),
    .count_i    (count_r),
    .byte_i     (in_tdata),
    .eos_i      (in_tuser),
    .phase_o    (phase_nxt),
    .ident_o    (ident_nxt),
    .tag_acc_o  (tag_acc_nxt),
    .len_acc_o  (len_acc_nxt),
    .left_o     (left_nxt),
    .count_o    (count_nxt),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // header state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDENT;
      ident_r   <= 8'd0;
      tag_acc_r <= '0;
      len_acc_r <= '0;
      left_r    <= 7'd0;
      count_r   <= 8'd0;
    end else if (in_acc) begin
      phase_r   <= phase_nxt;
      ident_r   <= ident_nxt;
      tag_acc_r <= tag_acc_nxt;
      len_acc_r <= len_acc_nxt;
      left_r    <= left_nxt;
      count_r   <= count_nxt;
    end
  end

  // result register
  dertlh_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_i     (in_acc && res_valid),
    .res_i      (res),
    .out_tready (out_tready),
    .out_valid_o(out_tvalid),
    .free_o     (slot_free),
    .res_o      (res_q)
  );

  assign out_tuser = res_q.status;
  assign out_tdata = {6'd0, res_q.header_bytes, res_q.content_length,
                      res_q.tag_number, res_q.tag_class};

  // a finished header always returns the parser to the identifier phase
  a_result_ends_header: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && res_valid |=> phase_r == PH_IDENT)
    else $error("parser not at identifier after a result");

  // inside a header at least one byte has been counted
  a_count_in_header: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_IDENT |-> count_r != 8'd0)
    else $error("header byte count zero inside a header");

  // long-form length always has bytes still to come
  a_len_bytes_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LENBYTES |-> left_r != 7'd0)
    else $error("length byte counter empty in length phase");

endmodule

FILE: tb/dertlh_header_check.sv
// watches both streams of the der header parser, predicts each header and compares
module dertlh_header_check
  import dertlh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [79:0] out_tdata,
  input  logic [1:0]  out_tuser,
  output int          mismatches,
  output int          pending,
  output int          headers_seen,
  output int          errors_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted parser state
  phase_t      ph;
  logic [7:0]  id_byte;
  logic [31:0] tag_acc;
  logic [31:0] len_acc;
  logic [6:0]  len_left;
  logic [7:0]  hdr_count;

  result_t expected_headers[$];

  // build a finished header from the current identifier
  function automatic result_t close_header(input logic [1:0] status, input logic [31:0] len);
    result_t r;
    r = '0;
    r.status         = status;
    r.tag_class      = id_byte[7:6];
    r.tag_number     = (id_byte[4:0] == TAG_LONG_FORM) ? tag_acc : {27'd0, id_byte[4:0]};
    r.content_length = len;
    r.header_bytes   = hdr_count;
    ph = PH_IDENT;
    return r;
  endfunction

  // advance the predicted state by one item, returns 1 when a header completes
  function automatic bit decode_byte(input logic [7:0] b, input logic eos, output result_t r);
    r = '0;
    if (eos) begin
      if (ph == PH_IDENT) return 1'b0;
      r.status       = STAT_TRUNC;
      r.header_bytes = hdr_count;
      ph = PH_IDENT;
      return 1'b1;
    end
    if (hdr_count != COUNT_MAX) hdr_count++;
    case (ph)
      PH_IDENT: begin
        id_byte   = b;
        tag_acc   = '0;
        len_acc   = '0;
        len_left  = '0;
        hdr_count = 8'd1;
        ph = (b[4:0] == TAG_LONG_FORM) ? PH_TAGCONT : PH_LEN;
        return 1'b0;
      end
      PH_TAGCONT: begin
        tag_acc = {tag_acc[24:0], b[6:0]};
        if (!b[7]) ph = PH_LEN;
        return 1'b0;
      end
      PH_LEN: begin
        if (b == 8'd0 && id_byte == 8'd0) begin
          r = close_header(STAT_EOC, 32'd0);
          return 1'b1;
        end
        if (b == LEN_INDEF_BYTE) begin
          r = close_header(STAT_INDEF, 32'd0);
          return 1'b1;
        end
        if (b[7]) begin
          len_left = b[6:0];
          len_acc  = '0;
          ph = PH_LENBYTES;
          return 1'b0;
        end
        r = close_header(STAT_OK, {24'd0, b});
        return 1'b1;
      end
      default: begin
        len_acc = {len_acc[23:0], b};
        if (len_left != 7'd0) len_left--;
        if (len_left == 7'd0) begin
          r = close_header(STAT_OK, len_acc);
          return 1'b1;
        end
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 30) $error("%s expected 0x%0h got 0x%0h", name, want, got);
    end
  endfunction

  // predict on accepted bytes, compare on accepted headers
  always @(posedge clk) begin : watch
    result_t want;
    result_t fresh;
    if (!rst_n) begin
      ph        = PH_IDENT;
      id_byte   = '0;
      tag_acc   = '0;
      len_acc   = '0;
      len_left  = '0;
      hdr_count = '0;
      expected_headers.delete();
      mismatches   = 0;
      pending      <= 0;
      headers_seen = 0;
      errors_seen  = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (decode_byte(in_tdata, in_tuser, fresh)) expected_headers.push_back(fresh);
      end
      if (out_tvalid && out_tready) begin
        headers_seen++;
        if (out_tuser != STAT_OK) errors_seen++;
        if (expected_headers.size() == 0) begin
          mismatches++;
          if (mismatches <= 30) $error("header item 0x%0h arrived with none pending", out_tdata);
        end else begin
          want = expected_headers.pop_front();
          compare_field("status", 32'(want.status), 32'(out_tuser));
          compare_field("tag_class", 32'(want.tag_class), 32'(out_tdata[1:0]));
          compare_field("tag_number", want.tag_number, out_tdata[33:2]);
          compare_field("content_length", want.content_length, out_tdata[65:34]);
          compare_field("header_bytes", 32'(want.header_bytes), 32'(out_tdata[73:66]));
          compare_field("fill", 32'd0, 32'(out_tdata[79:74]));
        end
      end
      pending <= expected_headers.size();
    end
  end

endmodule

FILE: tb/der_tag_length_header_parser_core_tb.sv
// stimulus and verdict for the der tag-length header parser
module der_tag_length_header_parser_core_tb
  import dertlh_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [79:0] out_tdata;
  wire  [1:0]  out_tuser;

  int mismatches, pending, headers_seen, errors_seen;
  int sent_items = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  // bit 8 marks end of stream
  logic [8:0] frame_bytes[$];

  always #6 clk = ~clk;

  der_tag_length_header_parser_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  dertlh_header_check i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .pending     (pending),
    .headers_seen(headers_seen),
    .errors_seen (errors_seen)
  );

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 250;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(0, 99) >= 15);
    end
  end

  // offer one item and wait until it is taken
  task automatic put_byte(input logic [7:0] b, input logic eos);
    while (!steady && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[k]) put_byte(frame_bytes[k][7:0], frame_bytes[k][8]);
  endtask

  // one well-formed header with random content, sometimes cut short
  task automatic make_header();
    logic [7:0] b;
    int n;
    int cut;
    int pick;
    frame_bytes.delete();
    if ($urandom_range(0, 19) == 0) begin
      frame_bytes.push_back(9'h000);
      frame_bytes.push_back(9'h000);
    end else begin
      b = 8'($urandom);
      if ($urandom_range(0, 2) == 0) begin
        b[4:0] = TAG_LONG_FORM;
        frame_bytes.push_back({1'b0, b});
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
          frame_bytes.push_back({1'b0, k != n - 1, 7'($urandom)});
      end else begin
        if (b[4:0] == TAG_LONG_FORM) b[4:0] = 5'($urandom_range(0, 30));
        frame_bytes.push_back({1'b0, b});
      end
      pick = $urandom_range(0, 9);
      if (pick <= 4) begin
        frame_bytes.push_back({2'b00, 7'($urandom)});
      end else if (pick == 5) begin
        frame_bytes.push_back({1'b0, LEN_INDEF_BYTE});
      end else begin
        n = (pick == 9) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        frame_bytes.push_back({2'b01, 7'(n)});
        for (int k = 0; k < n; k++) frame_bytes.push_back({1'b0, 8'($urandom)});
      end
    end
    // truncation at a random point of the header
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      frame_bytes.push_back(9'h100);
    end
  endtask

  // stray bytes and end marks anywhere in the stream
  task automatic make_noise();
    int n;
    frame_bytes.delete();
    n = $urandom_range(1, 4);
    for (int k = 0; k < n; k++)
      frame_bytes.push_back({$urandom_range(0, 7) == 0, 8'($urandom)});
  endtask

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed headers
    put_byte(8'h00, 1'b1);                       // end mark between headers
    put_byte(8'h02, 1'b0); put_byte(8'h05, 1'b0); // short tag, short length
    put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0); // end-of-contents
    put_byte(8'hdf, 1'b0); put_byte(8'h83, 1'b0);
    put_byte(8'h7f, 1'b0); put_byte(8'h80, 1'b0); // long tag, indefinite length
    put_byte(8'h30, 1'b0); put_byte(8'h84, 1'b0);
    put_byte(8'hff, 1'b0); put_byte(8'hff, 1'b0);
    put_byte(8'hff, 1'b0); put_byte(8'hff, 1'b0); // largest length
    put_byte(8'h7f, 1'b0); put_byte(8'h00, 1'b0);
    put_byte(8'h7f, 1'b0);                       // long tag of zero, length 127
    put_byte(8'ha1, 1'b0); put_byte(8'h00, 1'b1); // cut after identifier
    put_byte(8'h9f, 1'b0); put_byte(8'h81, 1'b0);
    put_byte(8'h00, 1'b1);                       // cut inside long tag
    put_byte(8'h45, 1'b0); put_byte(8'h00, 1'b0); // zero length, nonzero identifier

    // oversized tag saturates the byte count, longest length field wraps
    frame_bytes.delete();
    frame_bytes.push_back({1'b0, 3'b110, TAG_LONG_FORM});
    for (int k = 0; k < 299; k++) frame_bytes.push_back({2'b01, 7'($urandom)});
    frame_bytes.push_back(9'h001);
    frame_bytes.push_back(9'h0ff);
    for (int k = 0; k < 127; k++) frame_bytes.push_back({1'b0, 8'($urandom)});
    send_frame();

    // random stream, mostly well-formed headers
    while (sent_items < 1050) begin
      steady   = (sent_items >= 800 && sent_items < 1000);
      if (sent_items >= 600) hold_req = 1'b1;
      if ($urandom_range(0, 99) < 15) make_noise();
      else make_header();
      send_frame();
    end
    in_tvalid <= 1'b0;
    steady = 1'b0;

    // drain
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run: %0d input items incl. end marks, %0d headers checked", sent_items,
             headers_seen);
    $display("run: %0d headers with error status, %0d field mismatches", errors_seen,
             mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
